// ===== hdl/multi_mapper_outer_bank_wrap_defines.svh =====
// ----------------------------------------------------------------------------
// Outer bank wrapper assertion macros
// Shared concurrent assertion helpers; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_MAPPER_OUTER_BANK_WRAP_DEFINES_SVH
`define MULTI_MAPPER_OUTER_BANK_WRAP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define MMOB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define MMOB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MMOB_ASSERT(label, clk, rstn, prop, msg)
`define MMOB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/mmob_pkg.sv =====
// ----------------------------------------------------------------------------
// Outer bank wrapper package
// Transaction types, register indexes, mode flags and fixed window addresses.
// ----------------------------------------------------------------------------
package mmob_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CHR_OUTER = 2'd0;
    localparam logic [1:0] REG_PRG_OUTER = 2'd1;
    localparam logic [1:0] REG_MODE_BITS = 2'd2;

    // Inner mapper kind in chr_outer[1:0]
    localparam logic [1:0] KIND_MMC1 = 2'd2;

    // mode_bits flag positions
    localparam int unsigned MODE_CHR_RAM    = 0;
    localparam int unsigned MODE_PRG_MASK16 = 2;
    localparam int unsigned MODE_PRG_FIX8   = 3;
    localparam int unsigned MODE_FIXED      = 4;
    localparam int unsigned MODE_CHR_MASK7F = 5;
    localparam int unsigned MODE_CHR_FIX8   = 6;

    // Bank size codes
    localparam logic [2:0] SIZE_1K  = 3'd0;
    localparam logic [2:0] SIZE_4K  = 3'd1;
    localparam logic [2:0] SIZE_8K  = 3'd2;
    localparam logic [2:0] SIZE_16K = 3'd3;
    localparam logic [2:0] SIZE_32K = 3'd4;

    // Window addresses and strides
    localparam logic [15:0] PRG_WIN_ADDR = 16'h8000;
    localparam logic [15:0] CHR_WIN_ADDR = 16'h0000;
    localparam logic [15:0] STEP_8K      = 16'h2000;
    localparam logic [15:0] STEP_16K     = 16'h4000;

    // Masks
    localparam logic [7:0] PRG_MASK_NARROW = 8'h0F;
    localparam logic [7:0] PRG_MASK_WIDE   = 8'h1F;
    localparam logic [7:0] CHR_MASK_7F     = 8'h7F;
    localparam logic [7:0] CHR_MASK_1F     = 8'h1F;
    localparam logic [7:0] CHR_MASK_FF     = 8'hFF;

    typedef struct packed {
        logic        func;
        logic [15:0] slot_addr;
        logic [7:0]  inner_bank;
    } req_t;

    typedef struct packed {
        logic [8:0]  bank;
        logic [2:0]  size_code;
        logic [15:0] target_addr;
        logic        use_ram;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [7:0] chr_outer;
        logic [7:0] prg_outer;
        logic [7:0] mode_bits;
    } cfg_t;

    // First mapping of a transaction plus the count of mappings still to follow
    typedef struct packed {
        logic [8:0]  bank;
        logic [2:0]  size_code;
        logic [15:0] target_addr;
        logic        use_ram;
        logic [1:0]  remain;
    } job_t;

endpackage

// ===== hdl/multi_mapper_outer_bank_wrap.sv =====
// ----------------------------------------------------------------------------
// Multi-mapper outer bank wrapper
// Merges inner mapper bank numbers with outer base/mask registers.
// ----------------------------------------------------------------------------
// A request is accepted at a rising edge with start high and busy low. Its
// mappings appear on rsp, one per cycle, starting the cycle after accept,
// each marked by rsp_strobe for exactly one cycle; the receiver cannot stall
// them, so it must take every strobed transaction. A request gives one
// mapping, except program requests in fixed-bank mode: two 16K banks give two
// and four 8K banks give four. A request holds the single result register for
// all of its mappings, which sets the rate; busy is high during all but the
// last of them, so the next request can be accepted while the
// final mapping of the previous one is shown. rsp.last marks that final
// mapping. The outer registers are written through cfg_wr/cfg_idx/cfg_data
// and should only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module multi_mapper_outer_bank_wrap (
    input  logic           clk,
    input  logic           rst_n,
    // request channel
    input  logic           start,
    output logic           busy,
    input  mmob_pkg::req_t req,
    // result channel
    output logic           rsp_strobe,
    output mmob_pkg::rsp_t rsp,
    // configuration write port
    input  logic           cfg_wr,
    input  logic [1:0]     cfg_idx,
    input  logic [7:0]     cfg_data
);

    mmob_pkg::cfg_t cfg;
    mmob_pkg::job_t job;
    logic           load;

    // Outer registers: chr_outer, prg_outer, mode_bits
    mmob_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    // Merge the inner bank with the outer base and mask for the first mapping
    mmob_decode u_decode (
        .req (req),
        .cfg (cfg),
        .job (job)
    );

    // Accept a transaction whenever the emitter is on its last mapping or idle
    assign load = start && !busy;

    // Hold the mapping and advance through the fixed-bank windows
    mmob_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .job_in     (job),
        .busy       (busy),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp)
    );

endmodule

// ===== hdl/mmob_cfg.sv =====
// ----------------------------------------------------------------------------
// Outer bank registers
// Holds the three outer registers written through the plain write port.
// ----------------------------------------------------------------------------
module mmob_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_idx,
    input  logic [7:0]         cfg_data,
    output mmob_pkg::cfg_t     cfg
);

    mmob_pkg::cfg_t cfg_reg;
    mmob_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                mmob_pkg::REG_CHR_OUTER: cfg_next.chr_outer = cfg_data;
                mmob_pkg::REG_PRG_OUTER: cfg_next.prg_outer = cfg_data;
                mmob_pkg::REG_MODE_BITS: cfg_next.mode_bits = cfg_data;
                default:                 cfg_next = cfg_reg; // unused index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/mmob_decode.sv =====
// ----------------------------------------------------------------------------
// Outer bank decode
// Merges the inner bank with the outer base and mask into the first mapping.
// ----------------------------------------------------------------------------
module mmob_decode (
    input  mmob_pkg::req_t req,
    input  mmob_pkg::cfg_t cfg,
    output mmob_pkg::job_t job
);

    logic [6:0] pbase;
    logic [8:0] cbase;
    logic [7:0] pmask;
    logic [7:0] cmask;
    logic [8:0] phi;
    logic [8:0] chi;
    logic       is_mmc1;

    always_comb
    begin
        pbase   = cfg.prg_outer[7:1];
        cbase   = {cfg.chr_outer, 1'b0};
        is_mmc1 = (cfg.chr_outer[1:0] == mmob_pkg::KIND_MMC1);
        pmask   = cfg.mode_bits[mmob_pkg::MODE_PRG_MASK16] ? mmob_pkg::PRG_MASK_NARROW
                                                           : mmob_pkg::PRG_MASK_WIDE;
        if (cfg.mode_bits[mmob_pkg::MODE_CHR_MASK7F])
            cmask = mmob_pkg::CHR_MASK_7F;
        else if (cfg.mode_bits[mmob_pkg::MODE_FIXED])
            cmask = mmob_pkg::CHR_MASK_1F;
        else
            cmask = mmob_pkg::CHR_MASK_FF;
        phi = {2'b00, pbase} & ~{1'b0, pmask};
        chi = cbase & ~{1'b0, cmask};

        job             = '0;
        job.target_addr = req.slot_addr;

        if (!req.func)
        begin
            if (cfg.mode_bits[mmob_pkg::MODE_FIXED])
            begin
                job.target_addr = mmob_pkg::PRG_WIN_ADDR;
                if (cfg.mode_bits[mmob_pkg::MODE_PRG_FIX8])
                begin
                    job.bank      = {2'b00, pbase};
                    job.size_code = mmob_pkg::SIZE_8K;
                    job.remain    = 2'd3;
                end
                else if (cfg.mode_bits[mmob_pkg::MODE_PRG_MASK16])
                begin
                    job.bank      = {3'b000, pbase[6:1]};
                    job.size_code = mmob_pkg::SIZE_16K;
                    job.remain    = 2'd1;
                end
                else
                begin
                    job.bank      = {4'b0000, pbase[6:2]};
                    job.size_code = mmob_pkg::SIZE_32K;
                end
            end
            else if (is_mmc1)
            begin
                job.bank      = {1'b0, phi[8:1]} | {1'b0, req.inner_bank & {1'b0, pmask[7:1]}};
                job.size_code = mmob_pkg::SIZE_16K;
            end
            else
            begin
                job.bank      = phi | {1'b0, req.inner_bank & pmask};
                job.size_code = mmob_pkg::SIZE_8K;
            end
        end
        else
        begin
            if (cfg.mode_bits[mmob_pkg::MODE_CHR_RAM])
            begin
                job.size_code   = mmob_pkg::SIZE_8K;
                job.target_addr = mmob_pkg::CHR_WIN_ADDR;
                job.use_ram     = 1'b1;
            end
            else if (cfg.mode_bits[mmob_pkg::MODE_CHR_FIX8])
            begin
                job.bank        = {3'b000, cfg.chr_outer[7:2]};
                job.size_code   = mmob_pkg::SIZE_8K;
                job.target_addr = mmob_pkg::CHR_WIN_ADDR;
            end
            else if (is_mmc1)
            begin
                job.bank      = {2'b00, chi[8:2]} | {1'b0, req.inner_bank & {2'b00, cmask[7:2]}};
                job.size_code = mmob_pkg::SIZE_4K;
            end
            else
            begin
                job.bank      = chi | {1'b0, req.inner_bank & cmask};
                job.size_code = mmob_pkg::SIZE_1K;
            end
        end
    end

endmodule

// ===== hdl/mmob_emit.sv =====
// ----------------------------------------------------------------------------
// Outer bank result emitter
// Result register that plays out one mapping per cycle of a transaction.
// ----------------------------------------------------------------------------
`include "multi_mapper_outer_bank_wrap_defines.svh"

module mmob_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  mmob_pkg::job_t job_in,
    output logic           busy,
    output logic           rsp_strobe,
    output mmob_pkg::rsp_t rsp
);

    logic           valid_reg;
    logic           valid_next;
    mmob_pkg::job_t job_reg;
    mmob_pkg::job_t job_next;
    logic [15:0]    step;

    assign step = (job_reg.size_code == mmob_pkg::SIZE_16K) ? mmob_pkg::STEP_16K
                                                            : mmob_pkg::STEP_8K;

    always_comb
    begin
        valid_next = 1'b0;
        job_next   = job_reg;
        if (load)
        begin
            valid_next = 1'b1;
            job_next   = job_in;
        end
        else if (valid_reg && (job_reg.remain != 2'd0))
        begin
            // advance to the next window of a fixed-bank transaction
            valid_next           = 1'b1;
            job_next.remain      = job_reg.remain - 2'd1;
            job_next.target_addr = job_reg.target_addr + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign busy            = valid_reg && (job_reg.remain != 2'd0);
    assign rsp_strobe      = valid_reg;
    assign rsp.bank        = job_reg.bank;
    assign rsp.size_code   = job_reg.size_code;
    assign rsp.target_addr = job_reg.target_addr;
    assign rsp.use_ram     = job_reg.use_ram;
    assign rsp.last        = !busy;

    `MMOB_ASSERT(a_cont_strobe, clk, rst_n,
        rsp_strobe && !rsp.last |=> rsp_strobe, "mapping dropped mid transaction")
    `MMOB_ASSERT(a_cont_bank, clk, rst_n,
        rsp_strobe && !rsp.last |=> $stable(rsp.bank) && $stable(rsp.size_code),
        "bank changed mid transaction")
    `MMOB_ASSERT(a_cont_addr, clk, rst_n,
        rsp_strobe && !rsp.last |=> rsp.target_addr != $past(rsp.target_addr),
        "window did not advance")
    `MMOB_ASSERT(a_no_load_busy, clk, rst_n, busy |-> !load, "transaction accepted while busy")
    `MMOB_ASSERT_ALWAYS(a_reset_idle, clk,
        !rst_n |=> !rsp_strobe && !busy, "output active in reset")

endmodule

// ===== tb/sv/mmob_map_checker.sv =====
// ----------------------------------------------------------------------------
// Outer bank wrapper mapping checker
// Tracks the outer registers from the write port, predicts the bank mappings
// of every accepted request and compares each strobed mapping in order.
// ----------------------------------------------------------------------------
module mmob_map_checker
    import mmob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  req_t       req,
    input  logic       rsp_strobe,
    input  rsp_t       rsp,
    input  logic       cfg_wr,
    input  logic [1:0] cfg_idx,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         maps_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] chr_outer_r;
    logic [7:0] prg_outer_r;
    logic [7:0] mode_r;
    rsp_t       bank_maps [$];
    int         miscompares = 0;

    assign fail_count = miscompares;

    // Push the mappings that one request must produce, oldest first.
    function automatic void map_request(input req_t r);
        rsp_t       m;
        logic [6:0] prg_base;
        logic [8:0] chr_base;
        logic [8:0] hi;
        logic [7:0] mask;
        logic       mmc1;
        mmc1 = (chr_outer_r[1:0] == KIND_MMC1);
        m    = '0;
        if (r.func == 1'b0) begin
            prg_base = prg_outer_r[7:1];
            if (mode_r[MODE_FIXED]) begin
                if (mode_r[MODE_PRG_FIX8]) begin
                    for (int k = 0; k < 4; k++) begin
                        m.bank        = {2'b00, prg_base};
                        m.size_code   = SIZE_8K;
                        m.target_addr = PRG_WIN_ADDR + STEP_8K * 16'(k);
                        m.last        = (k == 3);
                        bank_maps.push_back(m);
                    end
                end
                else if (mode_r[MODE_PRG_MASK16]) begin
                    m.bank        = {3'b000, prg_base[6:1]};
                    m.size_code   = SIZE_16K;
                    m.target_addr = PRG_WIN_ADDR;
                    bank_maps.push_back(m);
                    m.target_addr = PRG_WIN_ADDR + STEP_16K;
                    m.last        = 1'b1;
                    bank_maps.push_back(m);
                end
                else begin
                    m.bank        = {4'b0000, prg_base[6:2]};
                    m.size_code   = SIZE_32K;
                    m.target_addr = PRG_WIN_ADDR;
                    m.last        = 1'b1;
                    bank_maps.push_back(m);
                end
            end
            else begin
                mask = mode_r[MODE_PRG_MASK16] ? PRG_MASK_NARROW : PRG_MASK_WIDE;
                hi   = {2'b00, prg_base} & ~{1'b0, mask};
                if (mmc1) begin
                    m.bank      = (hi >> 1) | {1'b0, r.inner_bank & (mask >> 1)};
                    m.size_code = SIZE_16K;
                end
                else begin
                    m.bank      = hi | {1'b0, r.inner_bank & mask};
                    m.size_code = SIZE_8K;
                end
                m.target_addr = r.slot_addr;
                m.last        = 1'b1;
                bank_maps.push_back(m);
            end
        end
        else begin
            chr_base = {chr_outer_r, 1'b0};
            if (mode_r[MODE_CHR_RAM]) begin
                m.size_code   = SIZE_8K;
                m.target_addr = CHR_WIN_ADDR;
                m.use_ram     = 1'b1;
            end
            else if (mode_r[MODE_CHR_FIX8]) begin
                m.bank        = chr_base >> 3;
                m.size_code   = SIZE_8K;
                m.target_addr = CHR_WIN_ADDR;
            end
            else begin
                if (mode_r[MODE_CHR_MASK7F])
                    mask = CHR_MASK_7F;
                else if (mode_r[MODE_FIXED])
                    mask = CHR_MASK_1F;
                else
                    mask = CHR_MASK_FF;
                hi = chr_base & ~{1'b0, mask};
                if (mmc1) begin
                    m.bank      = (hi >> 2) | {1'b0, r.inner_bank & (mask >> 2)};
                    m.size_code = SIZE_4K;
                end
                else begin
                    m.bank      = hi | {1'b0, r.inner_bank & mask};
                    m.size_code = SIZE_1K;
                end
                m.target_addr = r.slot_addr;
            end
            m.last = 1'b1;
            bank_maps.push_back(m);
        end
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            miscompares++;
        end
    endfunction

    // Results of older requests sit at the head of the queue, so compare
    // before pushing the predictions of a request accepted at the same edge.
    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            chr_outer_r = '0;
            prg_outer_r = '0;
            mode_r      = '0;
            bank_maps.delete();
            maps_due <= 0;
        end
        else begin
            if (rsp_strobe) begin
                if (bank_maps.size() == 0) begin
                    $error("mapping with nothing pending: bank 0x%0h at 0x%0h",
                           rsp.bank, rsp.target_addr);
                    miscompares++;
                end
                else begin
                    want = bank_maps.pop_front();
                    check_field("bank", 16'(want.bank), 16'(rsp.bank));
                    check_field("size_code", 16'(want.size_code), 16'(rsp.size_code));
                    check_field("target_addr", want.target_addr, rsp.target_addr);
                    check_field("use_ram", 16'(want.use_ram), 16'(rsp.use_ram));
                    check_field("last", 16'(want.last), 16'(rsp.last));
                end
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_CHR_OUTER: chr_outer_r = cfg_data;
                    REG_PRG_OUTER: prg_outer_r = cfg_data;
                    REG_MODE_BITS: mode_r      = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                map_request(req);
            maps_due <= bank_maps.size();
        end
    end

endmodule

// ===== tb/sv/tb_multi_mapper_outer_bank_wrap.sv =====
// ----------------------------------------------------------------------------
// Outer bank wrapper testbench
// Walks the block through every program and pattern mode under directed
// register settings, then random register settings with random requests in
// bursts. A checker beside the block predicts and compares every mapping.
// ----------------------------------------------------------------------------
module tb_multi_mapper_outer_bank_wrap;
    timeunit 1ns;
    timeprecision 1ps;

    import mmob_pkg::*;

    localparam int         HALF_PERIOD   = 5;
    localparam int         RESET_CYCLES  = 8;
    localparam int         RAND_PHASES   = 9;
    localparam int         PHASE_ITEMS   = 36;
    localparam int         DRAIN_CYCLES  = 6;
    localparam logic [1:0] REG_UNUSED    = 2'd3;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    req_t       req      = '0;
    logic       cfg_wr   = 1'b0;
    logic [1:0] cfg_idx  = '0;
    logic [7:0] cfg_data = '0;
    logic       busy;
    logic       rsp_strobe;
    rsp_t       rsp;
    int         fail_count;
    int         maps_due;
    int         burst_left = 0;

    always #HALF_PERIOD clk = ~clk;

    multi_mapper_outer_bank_wrap DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp),
        .cfg_wr     (cfg_wr),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data)
    );

    mmob_map_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp),
        .cfg_wr     (cfg_wr),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .maps_due   (maps_due)
    );

    // Hold start and the request until the block takes the transaction.
    // Busy only changes on clock edges, so the value read right after the
    // edge is the one the block saw.
    task automatic send_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Wait for every predicted mapping, then a few quiet cycles. Start must
    // already be low; the first edge lets the checker count the last accept.
    task automatic settle();
        @(posedge clk);
        while (maps_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Drain the block, then write all three outer registers. A write to the
    // unused index follows; it must leave every register alone.
    task automatic reprogram(input cfg_t s);
        start <= 1'b0;
        settle();
        cfg_wr   <= 1'b1;
        cfg_idx  <= REG_CHR_OUTER;
        cfg_data <= s.chr_outer;
        @(posedge clk);
        cfg_idx  <= REG_PRG_OUTER;
        cfg_data <= s.prg_outer;
        @(posedge clk);
        cfg_idx  <= REG_MODE_BITS;
        cfg_data <= s.mode_bits;
        @(posedge clk);
        cfg_idx  <= REG_UNUSED;
        cfg_data <= 8'($urandom);
        @(posedge clk);
        cfg_wr   <= 1'b0;
    endtask

    // Directed register settings: one per mode, with priorities crossed.
    function automatic cfg_t directed_setting(input int k);
        case (k)
            0:       return '{8'hFF, 8'hFF, 8'h00}; // kind 3, wide masks
            1:       return '{8'hAE, 8'hFF, 8'h04}; // MMC1, narrow program mask
            2:       return '{8'hAE, 8'hFF, 8'h10}; // MMC1, fixed 32K, pattern mask 1F
            3:       return '{8'hFF, 8'hFF, 8'h14}; // two fixed 16K banks
            4:       return '{8'h7D, 8'hFE, 8'h1C}; // four 8K beat 16K; unused kind
            5:       return '{8'hFE, 8'h55, 8'h20}; // MMC1 pattern mask 7F
            6:       return '{8'hFF, 8'hFF, 8'h30}; // mask 7F beats 1F
            7:       return '{8'hFF, 8'h00, 8'h40}; // pattern 8K fixed bank
            8:       return '{8'hFF, 8'hFF, 8'hFF}; // RAM beats all pattern modes
            default: return '{8'h01, 8'hAB, 8'h41}; // RAM beats 8K fixed, kind 1
        endcase
    endfunction

    initial
    begin
        req_t item;
        cfg_t setting;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under the reset setting, then one program
        // and one pattern transaction per directed setting.
        send_request('{1'b0, 16'h0000, 8'h00});
        send_request('{1'b0, 16'hFFFF, 8'hFF});
        send_request('{1'b1, 16'h0000, 8'hFF});
        send_request('{1'b1, 16'hFFFF, 8'h00});
        for (int k = 0; k < 10; k++)
        begin
            reprogram(directed_setting(k));
            send_request('{1'b0, k[0] ? 16'hFFFF : 16'h8000, k[0] ? 8'hFF : 8'h5A});
            send_request('{1'b1, k[0] ? 16'h0400 : 16'h1C00, k[0] ? 8'hC3 : 8'hA5});
        end

        // Random: all-zero and all-one settings first, then random ones.
        // Send in bursts; now and then drain fully before the next burst.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                setting = '0;
            else if (p == 1)
                setting = '1;
            else
            begin
                setting.chr_outer = 8'($urandom);
                setting.prg_outer = 8'($urandom);
                setting.mode_bits = 8'($urandom);
            end
            reprogram(setting);
            burst_left = $urandom_range(0, 15);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item.func       = 1'($urandom_range(0, 1));
                item.slot_addr  = 16'($urandom);
                item.inner_bank = 8'($urandom);
                send_request(item);
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    start <= 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        settle();
                    else
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    burst_left = $urandom_range(0, 15);
                end
            end
        end

        start <= 1'b0;
        settle();
        if (fail_count == 0 && maps_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Drop the run if the block stops answering.
    initial
    begin
        #500_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
